/* src/psa_pkg.sv */
// Shared types, constants and a helper function of the pressure sensor acquisition block.
package psa_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned FINE_W   = 16;
    localparam int unsigned COARSE_W = 11;
    localparam int unsigned QUOT_W   = 17;
    localparam int unsigned CNT_W    = 5;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
    localparam logic [COARSE_W-1:0] COARSE_MIN = 11'd500;
    localparam logic [COARSE_W-1:0] COARSE_MAX = 11'd1500;
    localparam logic [COARSE_W-1:0] COARSE_RESET = 11'd1000;
    localparam logic [4:0]          FAULT_SCALE = 5'd25;

    // Division by 25 as a multiply by ceil(2^22/25) and a shift; exact below 199728.
    localparam logic [17:0] RECIP_25    = 18'd167773;
    localparam int unsigned RECIP_SHIFT = 22;

    // One leading quotient bit plus sixteen fraction bits.
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd16;

    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_FIRST_BP  = 3'd0;
    localparam logic [2:0] REG_SECOND_BP = 3'd1;
    localparam logic [2:0] REG_FIRST_PP  = 3'd2;
    localparam logic [2:0] REG_SECOND_PP = 3'd3;
    localparam logic [2:0] REG_HIGH_TH   = 3'd4;
    localparam logic [2:0] REG_LOW_TH    = 3'd5;
    localparam logic [2:0] REG_INIT_P    = 3'd6;

    localparam logic [SAMPLE_W-1:0] FIRST_BP_RST  = 12'd0;
    localparam logic [SAMPLE_W-1:0] SECOND_BP_RST = 12'd4095;
    localparam logic [FINE_W-1:0]   FIRST_PP_RST  = 16'd0;
    localparam logic [FINE_W-1:0]   SECOND_PP_RST = 16'd65535;
    localparam logic [SAMPLE_W-1:0] HIGH_TH_RST   = 12'd4000;
    localparam logic [SAMPLE_W-1:0] LOW_TH_RST    = 12'd100;
    localparam logic [FINE_W-1:0]   INIT_P_RST    = 16'd12500;

    typedef struct packed {
        logic [SAMPLE_W-1:0] first_bp;
        logic [SAMPLE_W-1:0] second_bp;
        logic [FINE_W-1:0]   first_pp;
        logic [FINE_W-1:0]   second_pp;
        logic [SAMPLE_W-1:0] high_th;
        logic [SAMPLE_W-1:0] low_th;
    } psa_cfg_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic div_step;
        logic div_first;
        logic mult;
        logic combine;
        logic finish;
    } psa_cmd_t;

    typedef struct packed {
        logic out_free;
    } psa_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_MULT,
        ST_COMBINE,
        ST_FINISH
    } psa_state_t;

    // Coarse pressure: fine*2/25, clamped to 500..1500.
    function automatic logic [COARSE_W-1:0] to_coarse(input logic [FINE_W-1:0] fine);
        logic [34:0] prod;
        logic [12:0] quot;
        logic [COARSE_W-1:0] res;
        prod = {18'd0, fine, 1'b0} * {17'd0, RECIP_25};
        quot = prod[34:RECIP_SHIFT];
        if (quot < 13'(COARSE_MIN)) begin
            res = COARSE_MIN;
        end else if (quot > 13'(COARSE_MAX)) begin
            res = COARSE_MAX;
        end else begin
            res = quot[COARSE_W-1:0];
        end
        return res;
    endfunction

endpackage

/* src/psa_cfg_regs.sv */
// Configuration register file with the APB-style write and read port.
module psa_cfg_regs
    import psa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output psa_cfg_t          cfg,
    output logic              seed_valid,
    output logic [FINE_W-1:0] seed_value
);

    psa_cfg_t          cfg_reg;
    logic [FINE_W-1:0] init_p_reg;
    logic              wr_en;
    logic [2:0]        index;

    assign wr_en = psel & penable & pwrite;
    assign index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_bp  <= FIRST_BP_RST;
            cfg_reg.second_bp <= SECOND_BP_RST;
            cfg_reg.first_pp  <= FIRST_PP_RST;
            cfg_reg.second_pp <= SECOND_PP_RST;
            cfg_reg.high_th   <= HIGH_TH_RST;
            cfg_reg.low_th    <= LOW_TH_RST;
            init_p_reg        <= INIT_P_RST;
        end else if (wr_en) begin
            unique case (index)
                REG_FIRST_BP:  cfg_reg.first_bp  <= pwdata[SAMPLE_W-1:0];
                REG_SECOND_BP: cfg_reg.second_bp <= pwdata[SAMPLE_W-1:0];
                REG_FIRST_PP:  cfg_reg.first_pp  <= pwdata[FINE_W-1:0];
                REG_SECOND_PP: cfg_reg.second_pp <= pwdata[FINE_W-1:0];
                REG_HIGH_TH:   cfg_reg.high_th   <= pwdata[SAMPLE_W-1:0];
                REG_LOW_TH:    cfg_reg.low_th    <= pwdata[SAMPLE_W-1:0];
                REG_INIT_P:    init_p_reg        <= pwdata[FINE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (index)
            REG_FIRST_BP:  prdata = {20'd0, cfg_reg.first_bp};
            REG_SECOND_BP: prdata = {20'd0, cfg_reg.second_bp};
            REG_FIRST_PP:  prdata = {16'd0, cfg_reg.first_pp};
            REG_SECOND_PP: prdata = {16'd0, cfg_reg.second_pp};
            REG_HIGH_TH:   prdata = {20'd0, cfg_reg.high_th};
            REG_LOW_TH:    prdata = {20'd0, cfg_reg.low_th};
            REG_INIT_P:    prdata = {16'd0, init_p_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg        = cfg_reg;
    assign seed_valid = wr_en && (index == REG_INIT_P);
    assign seed_value = pwdata[FINE_W-1:0];

endmodule

/* src/psa_ctrl.sv */
// Controller state machine that sequences one sample through the datapath.
module psa_ctrl
    import psa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  psa_status_t status,
    output psa_cmd_t    cmd
);

    psa_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cnt_next   = '0;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:    state_next = ST_COMBINE;
            ST_COMBINE: state_next = ST_FINISH;
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SETUP:   cmd.setup = 1'b1;
            ST_DIVIDE: begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (cnt_reg == '0);
            end
            ST_MULT:    cmd.mult    = 1'b1;
            ST_COMBINE: cmd.combine = 1'b1;
            ST_FINISH:  cmd.finish  = status.out_free;
            default: ;
        endcase
    end

endmodule

/* src/psa_datapath.sv */
// Datapath: clamp, fault check, serial divide, interpolation, selection and output register.
module psa_datapath
    import psa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  psa_cmd_t          cmd,
    output psa_status_t       status,
    input  psa_cfg_t          cfg,
    input  logic              seed_valid,
    input  logic [FINE_W-1:0] seed_value,
    input  logic [31:0]       s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,
    output logic [2:0]        m_tuser
);

    logic [SAMPLE_W-1:0] sample_reg;
    logic [FINE_W-1:0]   subst_reg;
    logic                dflt_reg;
    logic                monitor_reg;
    logic                hi_flag_reg, lo_flag_reg;
    logic [COARSE_W-1:0] pc_reg;

    logic                bypass_reg;
    logic [FINE_W-1:0]   bypass_val_reg;
    logic [SAMPLE_W-1:0] rem_reg;
    logic [SAMPLE_W-1:0] span_reg;
    logic [FINE_W-1:0]   mag_reg;
    logic                up_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [FINE_W-1:0]   part_reg;
    logic [FINE_W-1:0]   acq_reg;
    logic [FINE_W-1:0]   chosen_reg;

    logic [55:0]         out_data_reg;
    logic [2:0]          out_user_reg;
    logic                out_valid_reg;

    logic [FINE_W-1:0]   raw;
    logic [SAMPLE_W-1:0] clamped;
    logic                hi_flag_next, lo_flag_next;

    logic                b1_ge;
    logic [SAMPLE_W-1:0] hi_b, lo_b;
    logic [FINE_W-1:0]   hi_p, lo_p;
    logic                bypass_next;
    logic [FINE_W-1:0]   bypass_val_next;

    logic [12:0]         trial;
    logic                trial_ge;

    logic [32:0]         product;
    logic [FINE_W-1:0]   acq_next;
    logic [FINE_W-1:0]   fault_fine;
    logic [15:0]         fault_sum;
    logic [FINE_W-1:0]   coarse_in;
    logic [COARSE_W-1:0] coarse;

    // Input stage: clamp the sample and run the threshold checks.
    assign raw     = s_tdata[15:0];
    assign clamped = (raw > {4'd0, SAMPLE_MAX}) ? SAMPLE_MAX : raw[SAMPLE_W-1:0];

    always_comb begin
        hi_flag_next = hi_flag_reg;
        lo_flag_next = lo_flag_reg;
        if (!s_tuser[0]) begin
            hi_flag_next = clamped > cfg.high_th;
            lo_flag_next = clamped < cfg.low_th;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_flag_reg <= 1'b0;
            lo_flag_reg <= 1'b0;
        end else if (cmd.load) begin
            hi_flag_reg <= hi_flag_next;
            lo_flag_reg <= lo_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg  <= clamped;
            subst_reg   <= s_tdata[31:16];
            dflt_reg    <= s_tuser[1];
            monitor_reg <= ~s_tuser[0];
        end
    end

    // Setup: order the breakpoints, catch the saturating cases, prepare the divide.
    always_comb begin
        b1_ge = cfg.second_bp >= cfg.first_bp;
        hi_b  = b1_ge ? cfg.second_bp : cfg.first_bp;
        lo_b  = b1_ge ? cfg.first_bp  : cfg.second_bp;
        hi_p  = b1_ge ? cfg.second_pp : cfg.first_pp;
        lo_p  = b1_ge ? cfg.first_pp  : cfg.second_pp;
        bypass_next     = 1'b1;
        bypass_val_next = cfg.first_pp;
        if (cfg.first_bp == cfg.second_bp) begin
            bypass_val_next = cfg.first_pp;
        end else if (sample_reg >= hi_b) begin
            bypass_val_next = hi_p;
        end else if (sample_reg < lo_b) begin
            bypass_val_next = lo_p;
        end else begin
            bypass_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            bypass_reg     <= bypass_next;
            bypass_val_reg <= bypass_val_next;
            span_reg       <= hi_b - lo_b;
            up_reg         <= cfg.second_pp >= cfg.first_pp;
            mag_reg        <= (cfg.second_pp >= cfg.first_pp) ? cfg.second_pp - cfg.first_pp
                                                              : cfg.first_pp - cfg.second_pp;
        end
    end

    // Restoring divide, one quotient bit per cycle. The setup step loads the
    // distance from the first breakpoint. The first step takes the integer bit,
    // which is set only when the distance is at least the span.
    assign trial    = cmd.div_first ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign trial_ge = trial >= {1'b0, span_reg};

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            rem_reg  <= (sample_reg >= cfg.first_bp) ? sample_reg - cfg.first_bp
                                                     : cfg.first_bp - sample_reg;
        end else if (cmd.div_step) begin
            rem_reg  <= trial_ge ? SAMPLE_W'(trial - {1'b0, span_reg}) : trial[SAMPLE_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], trial_ge};
        end
    end

    // Scale the pressure difference by the fraction.
    assign product = {17'd0, mag_reg} * {16'd0, quot_reg};

    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            part_reg <= product[31:16];
        end
    end

    // Interpolated value and choice of the fine pressure.
    always_comb begin
        if (bypass_reg) begin
            acq_next = bypass_val_reg;
        end else if (up_reg) begin
            acq_next = cfg.first_pp + part_reg;
        end else begin
            acq_next = cfg.first_pp - part_reg;
        end
    end

    assign fault_sum  = 16'({5'd0, pc_reg} * {11'd0, FAULT_SCALE}) + 16'd1;
    assign fault_fine = {1'b0, fault_sum[15:1]};

    always_ff @(posedge aclk) begin
        if (cmd.combine) begin
            acq_reg <= acq_next;
            if (dflt_reg) begin
                chosen_reg <= subst_reg;
            end else if (hi_flag_reg || lo_flag_reg) begin
                chosen_reg <= fault_fine;
            end else begin
                chosen_reg <= acq_next;
            end
        end
    end

    // One coarse converter, shared by the seed write and the finish step.
    assign coarse_in = seed_valid ? seed_value : chosen_reg;
    assign coarse    = to_coarse(coarse_in);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= COARSE_RESET;
        end else if (seed_valid || cmd.finish) begin
            pc_reg <= coarse;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {1'b0, coarse, chosen_reg, acq_reg, sample_reg};
            out_user_reg <= {monitor_reg, lo_flag_reg, hi_flag_reg};
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tuser         = out_user_reg;

endmodule

/* src/pressure_sensor_acquisition.sv */
// Top level of the pressure sensor acquisition block.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid/s_tready    raw sample, substitute pressure, mode flags
//   m_*       out        m_tvalid/m_tready    clamped sample, pressures, fault and monitor flags
//   APB       in/out     psel/penable/pready  seven calibration and threshold registers
//
// An item passes through these steps in order: the input transfer, which captures and
// checks the sample, setup, the restoring divider that forms the fraction, multiply,
// combine and finish. Finish writes the result to the output register, and the next
// input transfer can follow in the next cycle, even while that result still waits.
// Finish stalls only while the output register is full and m_tready is low.
// Reset is synchronous and active low; no clearing pass is needed.
module pressure_sensor_acquisition
    import psa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [15:0] raw_sample, [31:16] substitute_pressure
    input  logic [31:0]       s_tdata,
    // [0] inhibit_diag, [1] default_mode
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [11:0] clamped_sample, [27:12] acquired_pressure, [43:28] fine_pressure,
    // [54:44] coarse_pressure, [55] zero
    output logic [55:0]       m_tdata,
    // [0] fault_high, [1] fault_low, [2] monitor_active
    output logic [2:0]        m_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    psa_cfg_t          cfg;
    psa_cmd_t          cmd;
    psa_status_t       status;
    logic              seed_valid;
    logic [FINE_W-1:0] seed_value;

    // The register port never stalls.
    assign pready = 1'b1;

    // Register file. A write of the initial pressure also reseeds the stored
    // coarse value inside the datapath.
    psa_cfg_regs u_cfg_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .cfg        (cfg),
        .seed_valid (seed_valid),
        .seed_value (seed_value)
    );

    // Controller: walks each item through setup, divide, multiply, combine and finish.
    psa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: all arithmetic, the fault flags, the stored coarse value and
    // the output register.
    psa_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .cfg        (cfg),
        .seed_valid (seed_valid),
        .seed_value (seed_value),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // The coarse value always lies in its clamp range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[54:44] >= COARSE_MIN) && (m_tdata[54:44] <= COARSE_MAX))
        else $error("coarse pressure outside its clamp range");

    // The coarse value is derived from the reported fine value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[54:44] == to_coarse(m_tdata[43:28]))
        else $error("coarse pressure does not match fine pressure");

    // One item is in work at a time: after a transfer the input stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in work");

endmodule
